// ===== design/wha_pkg.sv =====
// ----------------------------------------------------------------------------
// wha_pkg
// shared types and constants of the weighted histogram accumulator
// ----------------------------------------------------------------------------
package wha_pkg;

  localparam int NUM_BINS = 256;
  localparam int SLOT_W   = $clog2(NUM_BINS);
  localparam int DIV_W    = 96;
  localparam int CNT_W    = 7;
  localparam int IN_W     = 80;
  localparam int OUT_W    = 248;
  localparam int CFG_W    = 48;

  localparam logic [CNT_W-1:0] MUL_DIV_STEPS = CNT_W'(DIV_W);
  localparam logic [CNT_W-1:0] BIN_DIV_STEPS = CNT_W'(32);

  localparam logic REG_BIN_SPAN = 1'b0;
  localparam logic REG_BIN_BASE = 1'b1;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_ACCUM   = 2'd0,
    ST_IGNORED = 2'd1,
    ST_OUTSIDE = 2'd2,
    ST_READ    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQR,
    S_DEC,
    S_MUL_LO,
    S_MUL_HI,
    S_DIV_LD,
    S_DIV_RUN,
    S_UPD,
    S_BIN_LD,
    S_BIN_RUN,
    S_BIN_CHK,
    S_MEM_RD,
    S_MEM_USE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    sqr;
    logic    load_first;
    logic    pass;
    logic    mul_lo;
    logic    mul_hi;
    logic    div_ld_mul;
    logic    div_ld_bin;
    logic    div_step;
    logic    upd;
    logic    bin_chk;
    logic    ld_rdbin;
    logic    mem_rd;
    logic    mem_use;
    logic    out_ld;
    status_t out_status;
  } cmd_t;

  typedef struct packed {
    logic op_read;
    logic slot_ok;
    logic w_pos;
    logic ws_zero;
    logic bw_zero;
    logic div_done;
    logic in_window;
    logic out_free;
  } stat_t;

endpackage

// ===== design/weighted_histogram_accumulator.sv =====
// ----------------------------------------------------------------------------
// weighted_histogram_accumulator
// weighted running mean, mean of squares and windowed bin weights
// ----------------------------------------------------------------------------
//  port group | dir | contents
//  in_*       | in  | tdata: operation, sample_value, sample_weight, slot_index
//  out_*      | out | tdata: status, bin_number, bin_sum, weight_total,
//             |     |        running_mean, running_mean_square
//  cfg_*      | in  | index 0 bin span, index 1 bin_base
//
//  accumulate uses the shared 1-bit-per-cycle divider: two 96-step mul-div
//  passes plus a 32-step bin division; the first sample skips the mul-div
//  passes, binning off skips the bin division, and ignored weights and slot
//  reads use no division
//  rst_n is synchronous; bin store reads as zero after reset via valid bits
//  a stalled result waits in the output register while the next beat runs
// ----------------------------------------------------------------------------
module weighted_histogram_accumulator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // operation, sample_value, sample_weight, slot_index, zero pad
  input  logic [wha_pkg::IN_W-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // status, bin_number, bin_sum, weight_total, running_mean,
  // running_mean_square, zero pad
  output logic [wha_pkg::OUT_W-1:0] out_tdata,
  input  logic                      cfg_wr_en,
  input  logic                      cfg_index,
  input  logic [wha_pkg::CFG_W-1:0] cfg_data
);

  wha_pkg::cmd_t  cmd;
  wha_pkg::stat_t stat;

  wha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wha_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ===== design/wha_ctrl.sv =====
// ----------------------------------------------------------------------------
// wha_ctrl
// sequencer: steps one item through square, mul-div passes, binning and store
// ----------------------------------------------------------------------------
module wha_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  wha_pkg::stat_t stat,
  output wha_pkg::cmd_t  cmd
);

  wha_pkg::state_t  state_r, state_nxt;
  logic             pass_r, pass_nxt;
  wha_pkg::status_t code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wha_pkg::S_IDLE;
      pass_r  <= 1'b0;
      code_r  <= wha_pkg::ST_ACCUM;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    code_nxt  = code_r;
    case (state_r)
      wha_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = wha_pkg::S_SQR;
      end
      wha_pkg::S_SQR: state_nxt = wha_pkg::S_DEC;
      wha_pkg::S_DEC: begin
        if (stat.op_read) begin
          if (stat.slot_ok) begin
            code_nxt  = wha_pkg::ST_READ;
            state_nxt = wha_pkg::S_MEM_RD;
          end else begin
            code_nxt  = wha_pkg::ST_OUTSIDE;
            state_nxt = wha_pkg::S_OUT;
          end
        end else if (!stat.w_pos) begin
          code_nxt  = wha_pkg::ST_IGNORED;
          state_nxt = wha_pkg::S_OUT;
        end else if (stat.ws_zero) begin
          code_nxt  = wha_pkg::ST_ACCUM;
          state_nxt = wha_pkg::S_BIN_LD;
        end else begin
          code_nxt  = wha_pkg::ST_ACCUM;
          pass_nxt  = 1'b0;
          state_nxt = wha_pkg::S_MUL_LO;
        end
      end
      wha_pkg::S_MUL_LO: state_nxt = wha_pkg::S_MUL_HI;
      wha_pkg::S_MUL_HI: state_nxt = wha_pkg::S_DIV_LD;
      wha_pkg::S_DIV_LD: state_nxt = wha_pkg::S_DIV_RUN;
      wha_pkg::S_DIV_RUN: begin
        if (stat.div_done) state_nxt = wha_pkg::S_UPD;
      end
      wha_pkg::S_UPD: begin
        if (!pass_r) begin
          pass_nxt  = 1'b1;
          state_nxt = wha_pkg::S_MUL_LO;
        end else begin
          state_nxt = wha_pkg::S_BIN_LD;
        end
      end
      wha_pkg::S_BIN_LD: begin
        state_nxt = stat.bw_zero ? wha_pkg::S_OUT : wha_pkg::S_BIN_RUN;
      end
      wha_pkg::S_BIN_RUN: begin
        if (stat.div_done) state_nxt = wha_pkg::S_BIN_CHK;
      end
      wha_pkg::S_BIN_CHK: begin
        if (stat.in_window) begin
          state_nxt = wha_pkg::S_MEM_RD;
        end else begin
          code_nxt  = wha_pkg::ST_OUTSIDE;
          state_nxt = wha_pkg::S_OUT;
        end
      end
      wha_pkg::S_MEM_RD:  state_nxt = wha_pkg::S_MEM_USE;
      wha_pkg::S_MEM_USE: state_nxt = wha_pkg::S_OUT;
      wha_pkg::S_OUT: begin
        if (stat.out_free) state_nxt = wha_pkg::S_IDLE;
      end
      default: state_nxt = wha_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.pass       = pass_r;
    cmd.out_status = code_r;
    in_tready      = 1'b0;
    case (state_r)
      wha_pkg::S_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      wha_pkg::S_SQR: cmd.sqr = 1'b1;
      wha_pkg::S_DEC: begin
        cmd.ld_rdbin   = stat.op_read;
        cmd.load_first = !stat.op_read && stat.w_pos && stat.ws_zero;
      end
      wha_pkg::S_MUL_LO:  cmd.mul_lo = 1'b1;
      wha_pkg::S_MUL_HI:  cmd.mul_hi = 1'b1;
      wha_pkg::S_DIV_LD:  cmd.div_ld_mul = 1'b1;
      wha_pkg::S_DIV_RUN: cmd.div_step = !stat.div_done;
      wha_pkg::S_UPD:     cmd.upd = 1'b1;
      wha_pkg::S_BIN_LD:  cmd.div_ld_bin = !stat.bw_zero;
      wha_pkg::S_BIN_RUN: cmd.div_step = !stat.div_done;
      wha_pkg::S_BIN_CHK: cmd.bin_chk = 1'b1;
      wha_pkg::S_MEM_RD:  cmd.mem_rd = 1'b1;
      wha_pkg::S_MEM_USE: cmd.mem_use = 1'b1;
      wha_pkg::S_OUT:     cmd.out_ld = stat.out_free;
      default: ;
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> !in_tready)
    else $error("input taken while item in flight");

endmodule

// ===== design/wha_dpath.sv =====
// ----------------------------------------------------------------------------
// wha_dpath
// datapath: shared multiplier, shared restoring divider, accumulators, bin store
// ----------------------------------------------------------------------------
module wha_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [wha_pkg::IN_W-1:0]   in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [wha_pkg::OUT_W-1:0]  out_tdata,
  input  logic                       cfg_wr_en,
  input  logic                       cfg_index,
  input  logic [wha_pkg::CFG_W-1:0]  cfg_data,
  input  wha_pkg::cmd_t              cmd,
  output wha_pkg::stat_t             stat
);

  // item registers
  logic                        op_r;
  logic signed [31:0]          v_r;
  logic [31:0]                 w_r;
  logic [7:0]                  slot_in_r;
  logic [63:0]                 sq_r;

  // accumulators and config
  logic [47:0]                 ws_r;
  logic [31:0]                 mean_r;
  logic [63:0]                 msq_r;
  logic [30:0]                 bw_r;
  logic [47:0]                 base_r;

  // mul-div
  logic [63:0]                 pp_lo_r, pp_hi_r;
  logic [48:0]                 den_r, rem_r;
  logic [wha_pkg::DIV_W-1:0]   quo_r;
  logic [wha_pkg::CNT_W-1:0]   cnt_r;

  // result
  logic [47:0]                 bin_r, bsum_r;
  logic [wha_pkg::SLOT_W-1:0]  slot_r;

  // bin store
  logic [47:0]                 mem [wha_pkg::NUM_BINS];
  logic [wha_pkg::NUM_BINS-1:0] vld_r;
  logic [47:0]                 mem_q_r;
  logic                        mem_v_r;

  logic                        out_valid_r;
  logic [wha_pkg::OUT_W-1:0]   out_data_r;

  logic [31:0]                 mag_v;
  logic [32:0]                 diff, diff_mag;
  logic                        neg;
  logic [63:0]                 a_op;
  logic [31:0]                 mul_a, mul_b;
  logic [63:0]                 prod;
  logic [49:0]                 rem_sh;
  logic                        ge;
  logic [47:0]                 binv;
  logic [48:0]                 slot_d;
  logic                        in_window;
  logic [48:0]                 ws_sum, den_sum, bin_add;
  logic [47:0]                 ws_sat, bin_sat, mem_cur;
  logic [wha_pkg::SLOT_W-1:0]  rd_addr;
  logic [63:0]                 q64;

  assign mag_v    = v_r[31] ? (~v_r + 32'd1) : v_r;
  assign diff     = {v_r[31], v_r} - {mean_r[31], mean_r};
  assign diff_mag = diff[32] ? (~diff + 33'd1) : diff;

  always_comb begin
    if (!cmd.pass) begin
      neg  = diff[32];
      a_op = 64'(diff_mag);
    end else begin
      neg  = sq_r < msq_r;
      a_op = neg ? (msq_r - sq_r) : (sq_r - msq_r);
    end
  end

  always_comb begin
    mul_a = mag_v;
    mul_b = mag_v;
    if (cmd.mul_lo) begin
      mul_a = a_op[31:0];
      mul_b = w_r;
    end else if (cmd.mul_hi) begin
      mul_a = a_op[63:32];
      mul_b = w_r;
    end
  end

  assign prod   = mul_a * mul_b;
  assign rem_sh = {rem_r, quo_r[wha_pkg::DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign q64    = quo_r[63:0];

  assign binv      = v_r[31] ? ~{16'd0, quo_r[31:0]} : {16'd0, quo_r[31:0]};
  assign slot_d    = {binv[47], binv} - {base_r[47], base_r};
  assign in_window = !slot_d[48] && (slot_d < 49'(wha_pkg::NUM_BINS));

  assign ws_sum  = {1'b0, ws_r} + 49'(w_r);
  assign ws_sat  = ws_sum[48] ? '1 : ws_sum[47:0];
  assign den_sum = {1'b0, ws_r} + 49'(w_r);
  assign mem_cur = mem_v_r ? mem_q_r : '0;
  assign bin_add = {1'b0, mem_cur} + 49'(w_r);
  assign bin_sat = bin_add[48] ? '1 : bin_add[47:0];
  assign rd_addr = op_r ? wha_pkg::SLOT_W'(slot_in_r) : slot_r;

  assign stat.op_read   = op_r == wha_pkg::OP_READ;
  assign stat.slot_ok   = 32'(slot_in_r) < 32'(wha_pkg::NUM_BINS);
  assign stat.w_pos     = !w_r[31] && (w_r != '0);
  assign stat.ws_zero   = ws_r == '0;
  assign stat.bw_zero   = bw_r == '0;
  assign stat.div_done  = cnt_r == '0;
  assign stat.in_window = in_window;
  assign stat.out_free  = !out_valid_r || out_tready;

  // control and accumulator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r        <= '0;
      mean_r      <= '0;
      msq_r       <= '0;
      bw_r        <= 31'd65536;
      base_r      <= -48'sd128;
      vld_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == wha_pkg::REG_BIN_SPAN) bw_r <= cfg_data[30:0];
        else base_r <= cfg_data;
      end
      if (cmd.load_first) begin
        mean_r <= v_r;
        msq_r  <= sq_r;
        ws_r   <= 48'(w_r);
      end
      if (cmd.upd) begin
        if (!cmd.pass) begin
          mean_r <= neg ? (mean_r - q64[31:0]) : (mean_r + q64[31:0]);
        end else begin
          msq_r <= neg ? (msq_r - q64) : (msq_r + q64);
          ws_r  <= ws_sat;
        end
      end
      if (cmd.div_ld_mul) cnt_r <= wha_pkg::MUL_DIV_STEPS;
      else if (cmd.div_ld_bin) cnt_r <= wha_pkg::BIN_DIV_STEPS;
      else if (cmd.div_step) cnt_r <= cnt_r - 1'b1;
      if (cmd.mem_use && !op_r) vld_r[slot_r] <= 1'b1;
      if (cmd.out_ld) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r      <= in_tdata[0];
      v_r       <= in_tdata[32:1];
      w_r       <= in_tdata[64:33];
      slot_in_r <= in_tdata[72:65];
      bin_r     <= '0;
      bsum_r    <= '0;
    end
    if (cmd.sqr)    sq_r    <= prod;
    if (cmd.mul_lo) pp_lo_r <= prod;
    if (cmd.mul_hi) pp_hi_r <= prod;
    if (cmd.div_ld_mul) begin
      quo_r <= {32'd0, pp_lo_r} + {pp_hi_r, 32'd0};
      den_r <= den_sum;
      rem_r <= '0;
    end else if (cmd.div_ld_bin) begin
      quo_r <= {mag_v, 64'd0};
      den_r <= 49'(bw_r);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? 49'(rem_sh - {1'b0, den_r}) : rem_sh[48:0];
      quo_r <= {quo_r[wha_pkg::DIV_W-2:0], ge};
    end
    if (cmd.ld_rdbin) bin_r <= base_r + 48'(slot_in_r);
    if (cmd.bin_chk) begin
      bin_r  <= binv;
      slot_r <= slot_d[wha_pkg::SLOT_W-1:0];
    end
    if (cmd.mem_use) bsum_r <= op_r ? mem_cur : bin_sat;
    if (cmd.out_ld) begin
      out_data_r <= {6'd0, msq_r, mean_r, ws_r, bsum_r, bin_r, cmd.out_status};
    end
  end

  // bin store
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      mem_q_r <= mem[rd_addr];
      mem_v_r <= vld_r[rd_addr];
    end
    if (cmd.mem_use && !op_r) mem[slot_r] <= bin_sat;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_step_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> cnt_r != '0)
    else $error("divider stepped past its end");

  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> (!out_valid_r || out_tready))
    else $error("result overwrote a pending beat");

  a_use_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_use |-> $past(cmd.mem_rd))
    else $error("store data used without a read");

  a_ws_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd && cmd.pass) |=> ws_r >= $past(ws_r))
    else $error("weight sum decreased");

endmodule

// ===== sim/tb_weighted_histogram_accumulator.sv =====
// ----------------------------------------------------------------------------
// tb_weighted_histogram_accumulator
// self-checking bench: a behavioral predictor of the weighted mean, mean of
// squares and bin store is fed every accepted beat; each output beat is
// compared field by field with the oldest prediction under random stalls
// ----------------------------------------------------------------------------
module tb_weighted_histogram_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1500000;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    wha_pkg::status_t status;
    logic [47:0] bin_number;
    logic [47:0] bin_sum;
    logic [47:0] weight_total;
    logic [31:0] running_mean;
    logic [63:0] running_mean_square;
  } hist_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [wha_pkg::IN_W-1:0] in_tdata = '0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [wha_pkg::OUT_W-1:0] out_tdata;
  logic                     cfg_wr_en = 1'b0;
  logic                     cfg_index = wha_pkg::REG_BIN_SPAN;
  logic [wha_pkg::CFG_W-1:0] cfg_data = '0;

  // predictor state
  logic [47:0]          bin_weights [wha_pkg::NUM_BINS];
  logic [47:0]          sum_of_weights;
  logic signed [63:0]   mean_now;
  logic [63:0]          mean_sq_now;
  logic [30:0]          width_reg;
  logic signed [47:0]   base_reg;

  hist_result_t         pending_results [$];
  int                   mismatch_count = 0;
  int                   beats_sent = 0;
  int                   beats_checked = 0;
  int                   cycle_count = 0;
  int                   burst_left = 0;
  int                   ready_mode = 0;

  weighted_histogram_accumulator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stall pattern: always ready, random, or long stalls
  always @(posedge clk) begin
    if (cycle_count % 97 == 0) ready_mode <= $urandom_range(0, 3);
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 1) == 1);
      2: out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= ((cycle_count / 13) % 2 == 0);
    endcase
  end

  function automatic logic [63:0] scaled_ratio(logic [63:0] a, logic [63:0] b, logic [63:0] c);
    logic [127:0] prod;
    prod = 128'(a) * 128'(b);
    return 64'(prod / 128'(c));
  endfunction

  function automatic logic [47:0] sat_sum48(logic [47:0] a, logic [63:0] b);
    logic [63:0] s;
    s = 64'(a) + b;
    return (s > 64'(MAX48)) ? MAX48 : s[47:0];
  endfunction

  function automatic hist_result_t predict_histogram(logic op, logic signed [31:0] v,
                                                     logic signed [31:0] w, logic [7:0] slot);
    hist_result_t r;
    logic signed [63:0] bin, diff, slot_off;
    logic [63:0] uw, mag, sq, den, q;
    r = '0;
    bin = 0;
    if (op == wha_pkg::OP_READ) begin
      bin = 64'(base_reg) + 64'(slot);
      r.status = wha_pkg::ST_READ;
      r.bin_sum = bin_weights[slot];
    end else if (w <= 0) begin
      r.status = wha_pkg::ST_IGNORED;
    end else begin
      uw = 64'(w);
      mag = (v < 0) ? 64'(-64'(v)) : 64'(v);
      sq = mag * mag;
      if (sum_of_weights == 0) begin
        mean_now = 64'(v);
        mean_sq_now = sq;
        sum_of_weights = uw[47:0];
      end else begin
        den = 64'(sum_of_weights) + uw;
        diff = 64'(v) - mean_now;
        if (diff < 0) begin
          q = scaled_ratio(64'(-diff), uw, den);
          mean_now = mean_now - q;
        end else begin
          q = scaled_ratio(64'(diff), uw, den);
          mean_now = mean_now + q;
        end
        if (sq >= mean_sq_now) mean_sq_now = mean_sq_now + scaled_ratio(sq - mean_sq_now, uw, den);
        else mean_sq_now = mean_sq_now - scaled_ratio(mean_sq_now - sq, uw, den);
        sum_of_weights = sat_sum48(sum_of_weights, uw);
      end
      r.status = wha_pkg::ST_ACCUM;
      if (width_reg != 0) begin
        if (v == 0) bin = 0;
        else if (v > 0) bin = mag / 64'(width_reg);
        else bin = -$signed(mag / 64'(width_reg)) - 1;
        slot_off = bin - 64'(base_reg);
        if (slot_off >= 0 && slot_off < wha_pkg::NUM_BINS) begin
          bin_weights[slot_off] = sat_sum48(bin_weights[slot_off], uw);
          r.bin_sum = bin_weights[slot_off];
        end else begin
          r.status = wha_pkg::ST_OUTSIDE;
        end
      end
    end
    r.bin_number = bin[47:0];
    r.weight_total = sum_of_weights;
    r.running_mean = mean_now[31:0];
    r.running_mean_square = mean_sq_now;
    return r;
  endfunction

  // compare each output beat with the oldest prediction
  always @(posedge clk) begin
    hist_result_t exp_r, act_r;
    if (rst_n && out_tvalid && out_tready) begin
      act_r = out_tdata[$bits(hist_result_t)-1:0] == 0 ? '0 : '0;
      act_r.status = wha_pkg::status_t'(out_tdata[1:0]);
      act_r.bin_number = out_tdata[49:2];
      act_r.bin_sum = out_tdata[97:50];
      act_r.weight_total = out_tdata[145:98];
      act_r.running_mean = out_tdata[177:146];
      act_r.running_mean_square = out_tdata[241:178];
      if (pending_results.size() == 0) begin
        $display("%0t unexpected beat: actual %h", $time, act_r);
        mismatch_count <= mismatch_count + 1;
      end else begin
        exp_r = pending_results.pop_front();
        beats_checked <= beats_checked + 1;
        if (act_r.status != exp_r.status)
          $display("%0t status: expected %0d actual %0d", $time, exp_r.status, act_r.status);
        if (act_r.bin_number != exp_r.bin_number)
          $display("%0t bin_number: expected %h actual %h", $time, exp_r.bin_number,
                   act_r.bin_number);
        if (act_r.bin_sum != exp_r.bin_sum)
          $display("%0t bin_sum: expected %h actual %h", $time, exp_r.bin_sum, act_r.bin_sum);
        if (act_r.weight_total != exp_r.weight_total)
          $display("%0t weight_total: expected %h actual %h", $time, exp_r.weight_total,
                   act_r.weight_total);
        if (act_r.running_mean != exp_r.running_mean)
          $display("%0t running_mean: expected %h actual %h", $time, exp_r.running_mean,
                   act_r.running_mean);
        if (act_r.running_mean_square != exp_r.running_mean_square)
          $display("%0t running_mean_square: expected %h actual %h", $time,
                   exp_r.running_mean_square, act_r.running_mean_square);
        if (act_r != exp_r) mismatch_count <= mismatch_count + 1;
      end
    end
  end

  task automatic send_beat(logic op, logic [31:0] v, logic [31:0] w, logic [7:0] slot);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, slot, w, v, op};
    forever begin
      @(negedge clk);
      if (in_tready) break;
      @(posedge clk);
    end
    @(posedge clk);
    pending_results.push_back(predict_histogram(op, v, w, slot));
    beats_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [47:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == wha_pkg::REG_BIN_SPAN) width_reg = value[30:0];
    else base_reg = value;
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_beat(wha_pkg::OP_ACCUM, 32'h0001_0000, 32'h0000_0000, 8'd0);
    send_beat(wha_pkg::OP_ACCUM, 32'h0001_0000, 32'h8000_0000, 8'd0);
    send_beat(wha_pkg::OP_ACCUM, 32'h0001_0000, 32'hFFFF_FFFF, 8'd0);
    send_beat(wha_pkg::OP_ACCUM, 32'h0002_8000, 32'h0001_0000, 8'hFF);
    send_beat(wha_pkg::OP_ACCUM, 32'h0000_0000, 32'h0000_0001, 8'd0);
    send_beat(wha_pkg::OP_ACCUM, 32'hFFFF_0000, 32'h0002_0000, 8'd0);
    send_beat(wha_pkg::OP_ACCUM, 32'hFFFF_FFFF, 32'h0000_8000, 8'd0);
    send_beat(wha_pkg::OP_ACCUM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0);
    send_beat(wha_pkg::OP_ACCUM, 32'h8000_0000, 32'h7FFF_FFFF, 8'd0);
    send_beat(wha_pkg::OP_ACCUM, 32'hFF80_0000, 32'h0001_0000, 8'd0);
    send_beat(wha_pkg::OP_ACCUM, 32'h007F_FFFF, 32'h0001_0000, 8'd0);
    send_beat(wha_pkg::OP_ACCUM, 32'h0080_0000, 32'h0001_0000, 8'd0);
    send_beat(wha_pkg::OP_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0);
    send_beat(wha_pkg::OP_READ, 32'd0, 32'd0, 8'd126);
    send_beat(wha_pkg::OP_READ, 32'd0, 32'd0, 8'd130);
    send_beat(wha_pkg::OP_READ, 32'd0, 32'd0, 8'd255);
    wait_idle();
    write_reg(wha_pkg::REG_BIN_SPAN, 48'd0);
    send_beat(wha_pkg::OP_ACCUM, 32'h0003_0000, 32'h0001_0000, 8'd0);
    send_beat(wha_pkg::OP_ACCUM, 32'hFFFD_0000, 32'h0000_0001, 8'd0);
    send_beat(wha_pkg::OP_READ, 32'd0, 32'd0, 8'd131);
    wait_idle();
  endtask

  task automatic test_random_phase(logic [30:0] bw, logic [47:0] base, int n_beats);
    int kind;
    logic signed [63:0] center;
    logic [31:0] v, w;
    write_reg(wha_pkg::REG_BIN_SPAN, 48'(bw));
    write_reg(wha_pkg::REG_BIN_BASE, base);
    for (int i = 0; i < n_beats; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        send_beat(wha_pkg::OP_READ, $urandom, $urandom, 8'($urandom));
      end else begin
        if ($urandom_range(0, 9) < 6 && bw != 0) begin
          center = (64'($signed(base)) + $urandom_range(0, wha_pkg::NUM_BINS - 1)) * 64'(bw);
          center = center + $urandom_range(0, 64'(bw) > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : bw);
          v = (center > 64'sh7FFF_FFFF || center < -64'sh8000_0000) ? $urandom : center[31:0];
        end else begin
          v = $urandom;
        end
        case ($urandom_range(0, 3))
          0: w = $urandom_range(1, 32'h0000_FFFF);
          1: w = $urandom_range(1, 32'h00FF_FFFF);
          2: w = $urandom_range(1, 32'h7FFF_FFFF);
          default: w = (kind < 32) ? 32'($urandom) | 32'h8000_0000 : $urandom_range(0, 3);
        endcase
        send_beat(wha_pkg::OP_ACCUM, v, w, 8'($urandom));
      end
      if (i == n_beats / 2 && $urandom_range(0, 1) == 1) begin
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
    end
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < wha_pkg::NUM_BINS; i++) bin_weights[i] = '0;
    sum_of_weights = '0;
    mean_now = 0;
    mean_sq_now = '0;
    width_reg = 31'd65536;
    base_reg = -48'sd128;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(31'd65536, -48'sd128, 200);
    test_random_phase(31'h7FFF_FFFF, -48'sd1, 100);
    test_random_phase(31'd1, 48'h8000_0000_0000, 80);
    test_random_phase(31'd1, 48'h7FFF_FFFF_FFFF, 60);
    test_random_phase(31'd0, 48'($urandom), 80);
    test_random_phase(31'($urandom_range(1, 32'h0010_0000)), -48'sd64, 200);
    test_random_phase(31'($urandom), 48'({$urandom, $urandom}), 100);
    $display("covered %0d beats over several bin widths and window bases, with stalls",
             beats_sent);
    $display("checked %0d result beats, %0d mismatching", beats_checked, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
